[hw/rtl/htnr_pkg.sv]
// ----------------------------------------------------------------------------
// htnr_pkg
// Shared types and constants of the height tile nearest-neighbor resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package htnr_pkg;

	localparam int MAX_SRC_SIDE_DEF = 256;
	localparam int OUT_SIDE_DEF     = 256;

	localparam int SIDE_W   = 9;
	localparam int GAIN_W   = 32;
	localparam int SAMPLE_W = 16;
	localparam int HEIGHT_W = 48;
	localparam int DATA_W   = 32;
	localparam int PADDR_W  = 3;

	localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(256);
	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(429497);

	localparam logic REG_SIDE = 1'b0;
	localparam logic REG_GAIN = 1'b1;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_SCAN = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_KICK,
		ST_DIV,
		ST_IDLE,
		ST_ADDR,
		ST_READ
	} state_t;

	typedef struct packed {
		cmd_t                        command;
		logic signed [SAMPLE_W-1:0]  sample;
	} in_word_t;

	typedef struct packed {
		logic signed [HEIGHT_W-1:0]  height;
		logic                        end_of_row;
		logic                        end_of_frame;
	} out_word_t;

endpackage

`default_nettype wire

[hw/rtl/height_tile_nearest_resample.sv]
// ----------------------------------------------------------------------------
// height_tile_nearest_resample
// Loads a square tile of elevation samples and scans it out, resampled to an
// OUT_SIDE by OUT_SIDE grid by nearest neighbor and scaled by a gain; cells
// of the first column and of the last row have height zero.
//   channel   handshake            word
//   input     start, busy          op     (command, sample)
//   output    done                 result (height, end_of_row, end_of_frame)
//   config    psel, penable, ...   src_side at 0x0, gain at 0x4
//
// A load writes the tile RAM at the edge that accepts it.
// A scan keeps busy high through ST_ADDR (address multiply) and ST_READ (RAM
// read); its word appears on result, with done, in the cycle after ST_READ.
// After reset and after every src_side write, busy stays high through ST_KICK
// and ST_DIV while M/(OUT_SIDE-1) is formed by a reciprocal multiplication.
// The receiver cannot stall; every result is taken in the cycle it shows.
// ----------------------------------------------------------------------------
`default_nettype none

module height_tile_nearest_resample #(
	parameter int MAX_SRC_SIDE = htnr_pkg::MAX_SRC_SIDE_DEF,
	parameter int OUT_SIDE     = htnr_pkg::OUT_SIDE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [htnr_pkg::PADDR_W-1:0]  paddr,
	input  logic [htnr_pkg::DATA_W-1:0]   pwdata,
	output logic [htnr_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          start,
	input  htnr_pkg::in_word_t            op,
	output logic                          busy,
	output logic                          done,
	output htnr_pkg::out_word_t           result
);

	import htnr_pkg::*;

	localparam int SW    = $clog2(MAX_SRC_SIDE + 1);
	localparam int DEPTH = MAX_SRC_SIDE * MAX_SRC_SIDE;
	localparam int AW    = $clog2(DEPTH);
	localparam int TW    = AW + 1;
	localparam int DW    = $clog2(OUT_SIDE);
	localparam int DEN   = OUT_SIDE - 1;

	state_t state_q, state_d;
	logic   div_start, res_load;

	logic [SIDE_W-1:0] side_q;
	logic [GAIN_W-1:0] gain_q;
	logic [AW-1:0]     load_pos_q;
	logic [DW-1:0]     row_q, col_q;
	logic [SW-1:0]     row_idx_q, col_idx_q;
	logic [DW-1:0]     row_rem_q, col_rem_q;

	logic [SW-1:0] row_pick_s1, col_pick_s1;
	logic          border_s1, eor_s1, eof_s1;

	logic      done_q;
	out_word_t result_q;

	logic          cfg_wr, side_wr, gain_wr;
	logic          accept, scan_acc, ram_we;
	logic [SW-1:0] m_eff;
	logic [TW-1:0] total, pos_inc;
	logic [AW-1:0] pos_eff, load_next, rd_addr;
	logic          last_col, last_row;
	logic          div_done;
	logic [SW-1:0] div_quo;
	logic [DW-1:0] div_rem;
	logic [DW:0]   col_sum, row_sum;
	logic          col_wrap, row_wrap;
	logic [DW-1:0] col_rem_n, row_rem_n;
	logic [SW-1:0] col_idx_n, row_idx_n;
	logic [SAMPLE_W-1:0]       rd_data;
	logic signed [HEIGHT_W:0]  prod;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign side_wr = cfg_wr && (paddr[2] == REG_SIDE);
	assign gain_wr = cfg_wr && (paddr[2] == REG_GAIN);
	assign prdata  = (paddr[2] == REG_SIDE) ? DATA_W'(side_q) : DATA_W'(gain_q);

	always_comb begin
		if (side_q == '0) begin
			m_eff = SW'(1);
		end else if (int'(side_q) > MAX_SRC_SIDE) begin
			m_eff = SW'(MAX_SRC_SIDE);
		end else begin
			m_eff = SW'(side_q);
		end
	end

	assign total     = TW'(m_eff) * TW'(m_eff);
	assign pos_eff   = (TW'(load_pos_q) < total) ? load_pos_q : '0;
	assign pos_inc   = TW'(pos_eff) + TW'(1);
	assign load_next = (pos_inc == total) ? '0 : AW'(pos_inc);

	assign accept   = start && !busy;
	assign scan_acc = accept && (op.command == CMD_SCAN);
	assign ram_we   = accept && (op.command == CMD_LOAD);

	assign last_col = col_q == DW'(DEN);
	assign last_row = row_q == DW'(DEN);

	assign col_sum   = (DW+1)'(col_rem_q) + (DW+1)'(div_rem);
	assign col_wrap  = col_sum >= (DW+1)'(DEN);
	assign col_rem_n = col_wrap ? DW'(col_sum - (DW+1)'(DEN)) : DW'(col_sum);
	assign col_idx_n = col_idx_q + div_quo + SW'(col_wrap);

	assign row_sum   = (DW+1)'(row_rem_q) + (DW+1)'(div_rem);
	assign row_wrap  = row_sum >= (DW+1)'(DEN);
	assign row_rem_n = row_wrap ? DW'(row_sum - (DW+1)'(DEN)) : DW'(row_sum);
	assign row_idx_n = row_idx_q + div_quo + SW'(row_wrap);

	htnr_div #(
		.DVD_W (SW),
		.REM_W (DW),
		.DEN   (DEN)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (m_eff),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_KICK;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		busy      = 1'b1;
		div_start = 1'b0;
		res_load  = 1'b0;
		unique case (state_q)
			ST_KICK: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start && (op.command == CMD_SCAN)) begin
					state_d = ST_ADDR;
				end
			end
			ST_ADDR: begin
				state_d = ST_READ;
			end
			ST_READ: begin
				res_load = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_KICK;
			end
		endcase
		if (side_wr) begin
			state_d = ST_KICK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q     <= SIDE_RESET;
			gain_q     <= GAIN_RESET;
			load_pos_q <= '0;
			row_q      <= '0;
			col_q      <= '0;
			row_idx_q  <= '0;
			col_idx_q  <= '0;
			row_rem_q  <= '0;
			col_rem_q  <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= res_load;
			if (gain_wr) begin
				gain_q <= pwdata[GAIN_W-1:0];
			end
			if (side_wr) begin
				side_q     <= pwdata[SIDE_W-1:0];
				load_pos_q <= '0;
				row_q      <= '0;
				col_q      <= '0;
				row_idx_q  <= '0;
				col_idx_q  <= '0;
				row_rem_q  <= '0;
				col_rem_q  <= '0;
			end else if (scan_acc) begin
				if (last_col) begin
					col_q     <= '0;
					col_idx_q <= '0;
					col_rem_q <= '0;
					if (last_row) begin
						row_q     <= '0;
						row_idx_q <= '0;
						row_rem_q <= '0;
					end else begin
						row_q     <= row_q + DW'(1);
						row_idx_q <= row_idx_n;
						row_rem_q <= row_rem_n;
					end
				end else begin
					col_q <= col_q + DW'(1);
					if (col_q != '0) begin
						col_idx_q <= col_idx_n;
						col_rem_q <= col_rem_n;
					end
				end
			end else if (ram_we) begin
				load_pos_q <= load_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_acc) begin
			row_pick_s1 <= (row_idx_q < m_eff) ? row_idx_q : m_eff - SW'(1);
			col_pick_s1 <= (col_idx_q < m_eff) ? col_idx_q : m_eff - SW'(1);
			border_s1   <= (col_q == '0) || last_row;
			eor_s1      <= last_col;
			eof_s1      <= last_col && last_row;
		end
		if (res_load) begin
			result_q.height       <= border_s1 ? '0 : prod[HEIGHT_W-1:0];
			result_q.end_of_row   <= eor_s1;
			result_q.end_of_frame <= eof_s1;
		end
	end

	assign rd_addr = AW'(TW'(row_pick_s1) * TW'(m_eff) + TW'(col_pick_s1));

	htnr_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (DEPTH)
	) u_tile_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pos_eff),
		.wdata (op.sample),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign prod   = $signed(rd_data) * $signed({1'b0, gain_q});
	assign done   = done_q;
	assign result = result_q;

`ifndef ASSERT_OFF
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_READ))
		else $error("result strobe without a finished RAM read");

	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_IDLE))
		else $error("tile write while a scan or divide is in progress");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADDR) |-> (row_pick_s1 < m_eff) && (col_pick_s1 < m_eff))
		else $error("source index outside the tile");

	assert property (@(posedge clk) disable iff (!arst_n)
		TW'(load_pos_q) < total)
		else $error("load position beyond the tile");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside its wait state");
`endif

endmodule

`default_nettype wire

[hw/rtl/htnr_ram.sv]
// ----------------------------------------------------------------------------
// htnr_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module htnr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[hw/rtl/htnr_div.sv]
// ----------------------------------------------------------------------------
// htnr_div
// Division by a constant through a reciprocal multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module htnr_div #(
	parameter int DVD_W = 9,
	parameter int REM_W = 8,
	parameter int DEN   = 255
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	output logic             done,
	output logic [DVD_W-1:0] quotient,
	output logic [REM_W-1:0] remainder
);

	// The reciprocal is rounded up with enough fraction bits that the quotient
	// is exact for every dividend of DVD_W bits.
	localparam int SHIFT = DVD_W + $clog2(DEN);
	localparam int RW    = SHIFT + 1;
	localparam int PW    = DVD_W + RW;
	localparam longint RECIP = ((longint'(1) << SHIFT) + longint'(DEN) - longint'(1)) /
		longint'(DEN);
	localparam logic [RW-1:0] RECIP_L = RW'(RECIP);
	localparam logic [31:0]   DEN_L   = 32'(DEN);

	logic             step_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVD_W-1:0] quo_q;
	logic [REM_W-1:0] rem_q;
	logic [PW-1:0]    prod;
	logic [31:0]      back;

	assign prod = PW'(dividend) * PW'(RECIP_L);
	assign back = 32'(quo_q) * DEN_L;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 1'b0;
		end else begin
			step_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			quo_q <= prod[SHIFT +: DVD_W];
		end else if (step_q) begin
			rem_q <= REM_W'(dvd_q - back[DVD_W-1:0]);
		end
	end

	assign done      = step_q && !start;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

[verif/htnr_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// htnr_tb_pkg
// Scoreboard for the height tile resampler: a cycle-free model of the tile
// store and scan position that turns every accepted scan word into the output
// cell it must produce, and checks the cells that come back in order.
// ----------------------------------------------------------------------------

package htnr_tb_pkg;

	import htnr_pkg::*;

	localparam int MAX_SIDE    = MAX_SRC_SIDE_DEF;
	localparam int GRID        = OUT_SIDE_DEF;
	localparam int STEP_DEN    = GRID - 1;
	localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int PRINT_CAP   = 40;

	class tile_resample_scoreboard;

		logic signed [SAMPLE_W-1:0] tile [STORE_DEPTH];
		bit                         written [STORE_DEPTH];
		int                         side_reg;
		logic [GAIN_W-1:0]          gain_reg;
		int load_pos, row, col, src_row, row_rem, src_col, col_rem;
		out_word_t                  pending_cells [$];
		int errors, loads, cells, row_ends, frame_ends;

		function new();
			side_reg = int'(SIDE_RESET);
			gain_reg = GAIN_RESET;
			restart();
		endfunction

		function void restart();
			load_pos = 0;
			row      = 0;
			col      = 0;
			src_row  = 0;
			row_rem  = 0;
			src_col  = 0;
			col_rem  = 0;
		endfunction

		function int side_eff();
			if (side_reg < 1) return 1;
			if (side_reg > MAX_SIDE) return MAX_SIDE;
			return side_reg;
		endfunction

		function void write_reg(logic idx, logic [DATA_W-1:0] value);
			if (idx == REG_SIDE) begin
				side_reg = int'(value[SIDE_W-1:0]);
				restart();
			end else begin
				gain_reg = value;
			end
		endfunction

		function void step_index(inout int idx, inout int rem, input int m);
			idx += m / STEP_DEN;
			rem += m % STEP_DEN;
			if (rem >= STEP_DEN) begin
				rem -= STEP_DEN;
				idx++;
			end
		endfunction

		function bit scan_reads_unwritten();
			int m, r, c;
			m = side_eff();
			if (col == 0 || row == GRID - 1) return 1'b0;
			r = (src_row < m) ? src_row : m - 1;
			c = (src_col < m) ? src_col : m - 1;
			return !written[r * m + c];
		endfunction

		function void note_word(in_word_t w);
			int m, total, pos, r, c;
			bit last_col, last_row;
			longint prod;
			out_word_t want;
			m = side_eff();
			total = m * m;
			if (w.command == CMD_LOAD) begin
				pos = (load_pos < total) ? load_pos : 0;
				tile[pos] = w.sample;
				written[pos] = 1'b1;
				pos++;
				load_pos = (pos >= total) ? 0 : pos;
				loads++;
				return;
			end
			last_col = (col == GRID - 1);
			last_row = (row == GRID - 1);
			want = '0;
			if (col != 0 && !last_row) begin
				r = (src_row < m) ? src_row : m - 1;
				c = (src_col < m) ? src_col : m - 1;
				prod = longint'(tile[r * m + c]) * longint'(gain_reg);
				want.height = prod[HEIGHT_W-1:0];
			end
			if (col != 0) step_index(src_col, col_rem, m);
			want.end_of_row   = last_col;
			want.end_of_frame = last_col && last_row;
			pending_cells.push_back(want);
			if (last_col) begin
				col     = 0;
				src_col = 0;
				col_rem = 0;
				if (last_row) begin
					row     = 0;
					src_row = 0;
					row_rem = 0;
				end else begin
					row++;
					step_index(src_row, row_rem, m);
				end
			end else begin
				col++;
			end
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= PRINT_CAP) $display("MISMATCH: %s", what);
		endtask

		task check_result(out_word_t got);
			out_word_t want;
			if (pending_cells.size() == 0) begin
				report_mismatch($sformatf("word with no cell pending, height %0d",
					got.height));
				return;
			end
			want = pending_cells.pop_front();
			cells++;
			if (want.end_of_row) row_ends++;
			if (want.end_of_frame) frame_ends++;
			if (got.height !== want.height)
				report_mismatch($sformatf("cell %0d height %0d, want %0d",
					cells, got.height, want.height));
			if (got.end_of_row !== want.end_of_row)
				report_mismatch($sformatf("cell %0d end_of_row %b, want %b",
					cells, got.end_of_row, want.end_of_row));
			if (got.end_of_frame !== want.end_of_frame)
				report_mismatch($sformatf("cell %0d end_of_frame %b, want %b",
					cells, got.end_of_frame, want.end_of_frame));
		endtask

	endclass

endpackage

[verif/height_tile_nearest_resample_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// height_tile_nearest_resample_tb
// Drives load and scan words into the resampler under a range of tile sides
// and gains, with random sender gaps, and checks every output cell against a
// scoreboard.
// ----------------------------------------------------------------------------

module height_tile_nearest_resample_tb;

	import htnr_pkg::*;
	import htnr_tb_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE      = 4;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]    pwdata;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;
	logic                 start;
	in_word_t             op;
	logic                 busy;
	logic                 done;
	out_word_t            result;

	tile_resample_scoreboard sb;
	int                      gap_pct;
	int                      reg_writes;
	int unsigned             cycle_count = 0;

	height_tile_nearest_resample i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.start   (start),
		.op      (op),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d cells still pending", cycle_count,
				sb.pending_cells.size());
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(result);
	end

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(7))
			0:       return 16'sh7FFF;
			1:       return 16'sh8000;
			2:       return 16'sh0000;
			3:       return 16'shFFFF;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic in_word_t make_word(cmd_t cmd, logic signed [SAMPLE_W-1:0] s);
		in_word_t w;
		w.command = cmd;
		w.sample  = s;
		return w;
	endfunction

	task automatic send_word(input in_word_t w);
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		op    <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_word(w);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (sb.pending_cells.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic cfg_write(input logic idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] readback;
		readback = (idx == REG_SIDE) ? (value & DATA_W'(9'h1FF)) : value;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.write_reg(idx, value);
		reg_writes++;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== readback)
			sb.report_mismatch($sformatf("register %0d reads %h, want %h", idx, prdata,
				readback));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(input logic [SIDE_W-1:0] side, input logic [GAIN_W-1:0] g,
		input int n_items);
		in_word_t w;
		wait_idle();
		cfg_write(REG_SIDE, ($urandom & ~32'h1FF) | DATA_W'(side));
		cfg_write(REG_GAIN, g);
		repeat (n_items) begin
			w.sample = rand_sample();
			if ($urandom_range(99) < 55 && !sb.scan_reads_unwritten()) w.command = CMD_SCAN;
			else w.command = CMD_LOAD;
			send_word(w);
		end
	endtask

	initial begin
		logic signed [SAMPLE_W-1:0] corner_samples [7];
		corner_samples = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001,
			16'sh5555, 16'shAAAA};
		sb         = new();
		gap_pct    = 12;
		reg_writes = 0;
		arst_n  <= 1'b0;
		start   <= 1'b0;
		op      <= '0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset side and gain: each load feeds the cell scanned right after it.
		send_word(make_word(CMD_SCAN, rand_sample()));
		foreach (corner_samples[i]) begin
			send_word(make_word(CMD_LOAD, corner_samples[i]));
			send_word(make_word(CMD_SCAN, rand_sample()));
		end

		// Full gain on a 2 by 2 tile; the fifth load wraps back to the first entry.
		wait_idle();
		cfg_write(REG_GAIN, 32'hFFFF_FFFF);
		cfg_write(REG_SIDE, 32'd2);
		for (int i = 0; i < 4; i++) send_word(make_word(CMD_LOAD, corner_samples[i]));
		send_word(make_word(CMD_LOAD, 16'sh8000));
		repeat (6) send_word(make_word(CMD_SCAN, rand_sample()));
		wait_idle();
		cfg_write(REG_GAIN, 32'd0);
		send_word(make_word(CMD_SCAN, rand_sample()));

		run_phase(9'd256, $urandom, 300);
		run_phase(9'd5, 32'd0, 250);
		gap_pct = 75;
		run_phase(9'd511, 32'hFFFF_FFFF, 300);
		run_phase(9'd0, $urandom, 250);
		gap_pct = 0;
		run_phase(9'd1, $urandom, 150);
		run_phase(SIDE_W'($urandom_range(2, 40)), $urandom, 250);
		run_phase(9'd257, $urandom, 150);

		start <= 1'b0;
		while (sb.pending_cells.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("Checked %0d cells (%0d row ends, %0d frame ends) after %0d loads.",
			sb.cells, sb.row_ends, sb.frame_ends, sb.loads);
		$display("Sides swept from 0 to 511 over %0d register writes, gains 0 to all ones.",
			reg_writes);
		if (sb.errors == 0 && sb.pending_cells.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[files.f]
hw/rtl/htnr_pkg.sv
hw/rtl/htnr_ram.sv
hw/rtl/htnr_div.sv
hw/rtl/height_tile_nearest_resample.sv
verif/htnr_tb_pkg.sv
verif/height_tile_nearest_resample_tb.sv
